// ----- rtl/unix_time_to_calendar_macros.svh -----
// Assertion macros shared by the calendar converter.
`ifndef UNIX_TIME_TO_CALENDAR_MACROS_SVH
`define UNIX_TIME_TO_CALENDAR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTCAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/utcal_pkg.sv -----
// Shared types and constants of the Unix time to calendar converter.
`timescale 1ns / 1ps

package utcal_pkg;

  // Seconds from 0001-01-01 to 1970-01-01, and the end of year 9999.
  localparam longint unsigned DAYS_TO_Y10000 = 64'd3652059;
  localparam longint unsigned SECS_PER_DAY   = 64'd86400;
  localparam logic signed [40:0] CIV_OFS = 41'sd62135596800;
  localparam logic signed [40:0] T_LIMIT = 41'(DAYS_TO_Y10000 * SECS_PER_DAY);
  localparam logic signed [16:0] ZONE_SCALE = 17'sd60;

  // Day split: t = 128 * x + low bits, then x / 675.
  localparam int unsigned DAY_LO_BITS = 7;
  localparam int unsigned DAY_DIV     = int'(SECS_PER_DAY) >> DAY_LO_BITS;
  localparam logic [22:0] DAY_RECIP   = 23'((64'd1 << 32) / 64'(DAY_DIV));

  localparam int unsigned MS_DIV    = 1000000;
  localparam int unsigned MS_MAX    = 999;
  localparam logic [10:0] MS_RECIP  = 11'((64'd1 << 30) / 64'(MS_DIV));

  localparam int unsigned DAYS_400Y = 365 * 400 + 97;
  localparam int unsigned DAYS_100Y = 365 * 100 + 24;
  localparam int unsigned DAYS_4Y   = 365 * 4 + 1;
  localparam int unsigned DAYS_1Y   = 365;
  localparam logic [4:0]  Y400_RECIP = 5'((64'd1 << 22) / 64'(DAYS_400Y));
  localparam logic [5:0]  Y4_RECIP   = 6'((64'd1 << 16) / 64'(DAYS_4Y));

  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam logic [5:0]  HR_RECIP  = 6'((64'd1 << 17) / 64'(SECS_PER_HOUR));
  localparam logic [6:0]  MIN_RECIP = 7'((64'd1 << 12) / 64'(SECS_PER_MIN));

  // Rounded-up reciprocal of 31, exact for day numbers below 1092.
  localparam logic [10:0] MON_RECIP = 11'(((64'd1 << 15) + 64'd30) / 64'd31);

  localparam int unsigned LEAP_DAY  = 31 + 29 - 1;
  localparam int unsigned LAST_MON  = 11;
  localparam int unsigned FEB       = 2;

  localparam logic [8:0] MONTH_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Number of stages in the converter pipeline.
  localparam int unsigned BACK_STAGES = 14;

  // Classified item handed from the front end to the converter pipeline.
  typedef struct packed {
    logic [38:0] t;
    logic [29:0] nanoseconds;
    logic        oor;
  } job_t;

endpackage

// ----- rtl/utcal_if.sv -----
// Channel interfaces of the calendar converter.
`timescale 1ns / 1ps

interface utcal_in_if;
  logic               valid;
  logic               ready;
  logic signed [38:0] unix_seconds;
  logic        [29:0] nanoseconds;
  modport source (output valid, output unix_seconds, output nanoseconds, input ready);
  modport sink (input valid, input unix_seconds, input nanoseconds, output ready);
endinterface

interface utcal_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] zone_minutes_west;
  modport source (output valid, output zone_minutes_west, input ready);
  modport sink (input valid, input zone_minutes_west, output ready);
endinterface

interface utcal_job_if;
  logic             valid;
  logic             ready;
  utcal_pkg::job_t  job;
  modport source (output valid, output job, input ready);
  modport sink (input valid, input job, output ready);
endinterface

interface utcal_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [9:0]  millisecond;
  logic        out_of_range;
  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output millisecond,
                  output out_of_range, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour, input minute, input second, input millisecond,
                input out_of_range, output ready);
endinterface

// ----- rtl/utcal_front.sv -----
// Front end: zone register, local time offset and range classification.
`timescale 1ns / 1ps

module utcal_front (
  input logic        clk,
  input logic        rst_n,
  utcal_in_if.sink   src,
  utcal_cfg_if.sink  cfg,
  utcal_job_if.source job
);

  logic signed [16:0] zsec_r, zsec_nxt;
  logic               vld_r, vld_nxt;
  utcal_pkg::job_t    job_r, job_nxt;
  logic signed [40:0] t_ext;
  logic               take;

  assign cfg.ready = 1'b1;
  assign src.ready = !vld_r || job.ready;
  assign take      = src.valid && src.ready;

  assign job.valid = vld_r;
  assign job.job   = job_r;

  always_comb begin
    zsec_nxt = zsec_r;
    if (cfg.valid) begin
      zsec_nxt = 17'(cfg.zone_minutes_west) * utcal_pkg::ZONE_SCALE;
    end
  end

  // Local seconds counted from 0001-01-01; anything outside 1..9999 is flagged.
  always_comb begin
    t_ext = 41'(src.unix_seconds) + utcal_pkg::CIV_OFS - 41'(zsec_r);
    job_nxt.t           = t_ext[38:0];
    job_nxt.nanoseconds = src.nanoseconds;
    job_nxt.oor         = t_ext[40] || (t_ext >= utcal_pkg::T_LIMIT);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (job.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zsec_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      zsec_r <= zsec_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ----- rtl/utcal_fifo.sv -----
// Small queue between the front end and the converter pipeline.
`timescale 1ns / 1ps

module utcal_fifo (
  input logic         clk,
  input logic         rst_n,
  utcal_job_if.sink   wr,
  utcal_job_if.source rd
);

  utcal_pkg::job_t                   mem_r [utcal_pkg::QUEUE_DEPTH];
  logic [utcal_pkg::QPTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [utcal_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              push, pop;

  assign wr.ready = (cnt_r != utcal_pkg::QCNT_W'(utcal_pkg::QUEUE_DEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.job   = mem_r[rp_r];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == utcal_pkg::QPTR_W'(utcal_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == utcal_pkg::QPTR_W'(utcal_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr.job;
    end
  end

endmodule

// ----- rtl/utcal_back.sv -----
// Converter pipeline: day split, year cycles, month lookup and time of day.
`timescale 1ns / 1ps

module utcal_back (
  input logic         clk,
  input logic         rst_n,
  utcal_job_if.sink   job,
  utcal_out_if.source res
);

  typedef struct packed {
    logic        oor;
    logic [31:0] x;
    logic [6:0]  lo7;
    logic [29:0] ns;
    logic [54:0] pday;
    logic [40:0] pms;
    logic [22:0] dq;
    logic [10:0] dr;
    logic [10:0] msq;
    logic [20:0] msr;
    logic [9:0]  ms;
    logic [21:0] days;
    logic [16:0] rem;
    logic [26:0] p400;
    logic [21:0] phr;
    logic [4:0]  n1;
    logic [18:0] d1;
    logic [4:0]  hq;
    logic [12:0] hr;
    logic [4:0]  hour;
    logic [11:0] r2;
    logic [1:0]  n2;
    logic [15:0] d2;
    logic [17:0] pmin;
    logic [5:0]  mq;
    logic [6:0]  mr;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [20:0] p4;
    logic [4:0]  n3;
    logic [11:0] d3;
    logic [1:0]  n4;
    logic [8:0]  d4;
    logic        leap;
    logic [13:0] year;
    logic        feb29;
    logic [8:0]  yday;
    logic [18:0] pmon;
    logic [3:0]  month;
    logic [4:0]  dom;
  } pipe_t;

  pipe_t        st_r   [1:utcal_pkg::BACK_STAGES];
  pipe_t        st_nxt [1:utcal_pkg::BACK_STAGES];
  logic [utcal_pkg::BACK_STAGES:1] vld_r, vld_nxt;
  logic         adv;

  // The whole pipeline moves together; it halts only while the last stage
  // holds a beat that the sink has not taken.
  assign adv       = !vld_r[utcal_pkg::BACK_STAGES] || res.ready;
  assign job.ready = adv;
  assign vld_nxt   = {vld_r[utcal_pkg::BACK_STAGES-1:1], job.valid};

  always_comb begin
    logic [3:0] mi;
    logic [8:0] mend;
    logic [8:0] mbeg;
    logic [10:0] msum;

    for (int k = 1; k <= utcal_pkg::BACK_STAGES; k++) begin
      st_nxt[k] = (k == 1) ? '0 : st_r[k-1];
    end

    // Reciprocal products for the day split and the millisecond.
    st_nxt[1].oor  = job.job.oor;
    st_nxt[1].x    = job.job.t[38:7];
    st_nxt[1].lo7  = job.job.t[6:0];
    st_nxt[1].ns   = job.job.nanoseconds;
    st_nxt[1].pday = 55'(job.job.t[38:7]) * 55'(utcal_pkg::DAY_RECIP);
    st_nxt[1].pms  = 41'(job.job.nanoseconds) * 41'(utcal_pkg::MS_RECIP);

    // Estimated quotients are low by at most one; the remainders tell.
    st_nxt[2].dq  = st_r[1].pday[54:32];
    st_nxt[2].dr  = 11'(st_r[1].x - 32'(st_r[1].pday[54:32]) * 32'(utcal_pkg::DAY_DIV));
    st_nxt[2].msq = st_r[1].pms[40:30];
    st_nxt[2].msr = 21'(st_r[1].ns - 30'(st_r[1].pms[40:30]) * 30'(utcal_pkg::MS_DIV));

    if (st_r[2].dr >= 11'(utcal_pkg::DAY_DIV)) begin
      st_nxt[3].days = 22'(st_r[2].dq + 23'd1);
      st_nxt[3].rem  = {10'(st_r[2].dr - 11'(utcal_pkg::DAY_DIV)), st_r[2].lo7};
    end else begin
      st_nxt[3].days = st_r[2].dq[21:0];
      st_nxt[3].rem  = {st_r[2].dr[9:0], st_r[2].lo7};
    end
    msum = st_r[2].msq + 11'(st_r[2].msr >= 21'(utcal_pkg::MS_DIV));
    st_nxt[3].ms = (msum > 11'(utcal_pkg::MS_MAX)) ? 10'(utcal_pkg::MS_MAX) : msum[9:0];

    st_nxt[4].p400 = 27'(st_r[3].days) * 27'(utcal_pkg::Y400_RECIP);
    st_nxt[4].phr  = 22'(st_r[3].rem) * 22'(utcal_pkg::HR_RECIP);

    st_nxt[5].n1 = st_r[4].p400[26:22];
    st_nxt[5].d1 = 19'(st_r[4].days
                       - 22'(st_r[4].p400[26:22]) * 22'(utcal_pkg::DAYS_400Y));
    st_nxt[5].hq = st_r[4].phr[21:17];
    st_nxt[5].hr = 13'(st_r[4].rem
                       - 17'(st_r[4].phr[21:17]) * 17'(utcal_pkg::SECS_PER_HOUR));

    if (st_r[5].d1 >= 19'(utcal_pkg::DAYS_400Y)) begin
      st_nxt[6].n1 = st_r[5].n1 + 5'd1;
      st_nxt[6].d1 = st_r[5].d1 - 19'(utcal_pkg::DAYS_400Y);
    end
    if (st_r[5].hr >= 13'(utcal_pkg::SECS_PER_HOUR)) begin
      st_nxt[6].hour = st_r[5].hq + 5'd1;
      st_nxt[6].r2   = 12'(st_r[5].hr - 13'(utcal_pkg::SECS_PER_HOUR));
    end else begin
      st_nxt[6].hour = st_r[5].hq;
      st_nxt[6].r2   = st_r[5].hr[11:0];
    end

    // Century within the 400-year cycle; the last day of the cycle stays
    // in the fourth century.
    priority if (st_r[6].d1 >= 19'(3 * utcal_pkg::DAYS_100Y)) begin
      st_nxt[7].n2 = 2'd3;
    end else if (st_r[6].d1 >= 19'(2 * utcal_pkg::DAYS_100Y)) begin
      st_nxt[7].n2 = 2'd2;
    end else if (st_r[6].d1 >= 19'(utcal_pkg::DAYS_100Y)) begin
      st_nxt[7].n2 = 2'd1;
    end else begin
      st_nxt[7].n2 = 2'd0;
    end
    st_nxt[7].d2   = 16'(st_r[6].d1 - 19'(st_nxt[7].n2) * 19'(utcal_pkg::DAYS_100Y));
    st_nxt[7].pmin = 18'(st_r[6].r2) * 18'(utcal_pkg::MIN_RECIP);

    st_nxt[8].p4 = 21'(st_r[7].d2) * 21'(utcal_pkg::Y4_RECIP);
    st_nxt[8].mq = st_r[7].pmin[17:12];
    st_nxt[8].mr = 7'(st_r[7].r2 - 12'(st_r[7].pmin[17:12]) * 12'(utcal_pkg::SECS_PER_MIN));

    st_nxt[9].n3 = st_r[8].p4[20:16];
    st_nxt[9].d3 = 12'(st_r[8].d2 - 16'(st_r[8].p4[20:16]) * 16'(utcal_pkg::DAYS_4Y));
    if (st_r[8].mr >= 7'(utcal_pkg::SECS_PER_MIN)) begin
      st_nxt[9].minute = st_r[8].mq + 6'd1;
      st_nxt[9].second = 6'(st_r[8].mr - 7'(utcal_pkg::SECS_PER_MIN));
    end else begin
      st_nxt[9].minute = st_r[8].mq;
      st_nxt[9].second = st_r[8].mr[5:0];
    end

    if (st_r[9].d3 >= 12'(utcal_pkg::DAYS_4Y)) begin
      st_nxt[10].n3 = st_r[9].n3 + 5'd1;
      st_nxt[10].d3 = st_r[9].d3 - 12'(utcal_pkg::DAYS_4Y);
    end

    priority if (st_r[10].d3 >= 12'(3 * utcal_pkg::DAYS_1Y)) begin
      st_nxt[11].n4 = 2'd3;
    end else if (st_r[10].d3 >= 12'(2 * utcal_pkg::DAYS_1Y)) begin
      st_nxt[11].n4 = 2'd2;
    end else if (st_r[10].d3 >= 12'(utcal_pkg::DAYS_1Y)) begin
      st_nxt[11].n4 = 2'd1;
    end else begin
      st_nxt[11].n4 = 2'd0;
    end
    st_nxt[11].d4 = 9'(st_r[10].d3 - 12'(st_nxt[11].n4) * 12'(utcal_pkg::DAYS_1Y));
    // Fourth year of a 4-year cycle is leap, except the last one of a
    // century that does not close a 400-year cycle.
    st_nxt[11].leap = (st_nxt[11].n4 == 2'd3)
                      && ((st_r[10].n3 != 5'd24) || (st_r[10].n2 == 2'd3));

    st_nxt[12].year = 14'(st_r[11].n1) * 14'd400 + 14'(st_r[11].n2) * 14'd100
                      + 14'(st_r[11].n3) * 14'd4 + 14'(st_r[11].n4) + 14'd1;
    st_nxt[12].feb29 = st_r[11].leap && (st_r[11].d4 == 9'(utcal_pkg::LEAP_DAY));
    if (st_r[11].leap && (st_r[11].d4 > 9'(utcal_pkg::LEAP_DAY))) begin
      st_nxt[12].yday = st_r[11].d4 - 9'd1;
    end else begin
      st_nxt[12].yday = st_r[11].d4;
    end

    st_nxt[13].pmon = 19'(st_r[12].yday) * 19'(utcal_pkg::MON_RECIP);

    // Month guess from day / 31 is at most one short.
    mi = st_r[13].pmon[18:15];
    if (mi > 4'(utcal_pkg::LAST_MON)) begin
      mi = 4'(utcal_pkg::LAST_MON);
    end
    mend = utcal_pkg::MONTH_START[mi + 4'd1];
    if ((st_r[13].yday >= mend) && (mi < 4'(utcal_pkg::LAST_MON))) begin
      mi   = mi + 4'd1;
      mbeg = mend;
    end else begin
      mbeg = utcal_pkg::MONTH_START[mi];
    end
    if (st_r[13].feb29) begin
      st_nxt[14].month = 4'(utcal_pkg::FEB);
      st_nxt[14].dom   = 5'd29;
    end else begin
      st_nxt[14].month = mi + 4'd1;
      st_nxt[14].dom   = 5'(st_r[13].yday - mbeg + 9'd1);
    end
    if (st_r[13].oor) begin
      st_nxt[14].year   = '0;
      st_nxt[14].month  = '0;
      st_nxt[14].dom    = '0;
      st_nxt[14].hour   = '0;
      st_nxt[14].minute = '0;
      st_nxt[14].second = '0;
      st_nxt[14].ms     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= utcal_pkg::BACK_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign res.valid        = vld_r[utcal_pkg::BACK_STAGES];
  assign res.year         = st_r[utcal_pkg::BACK_STAGES].year;
  assign res.month        = st_r[utcal_pkg::BACK_STAGES].month;
  assign res.day_of_month = st_r[utcal_pkg::BACK_STAGES].dom;
  assign res.hour         = st_r[utcal_pkg::BACK_STAGES].hour;
  assign res.minute       = st_r[utcal_pkg::BACK_STAGES].minute;
  assign res.second       = st_r[utcal_pkg::BACK_STAGES].second;
  assign res.millisecond  = st_r[utcal_pkg::BACK_STAGES].ms;
  assign res.out_of_range = st_r[utcal_pkg::BACK_STAGES].oor;

endmodule

// ----- rtl/unix_time_to_calendar.sv -----
// Unix time to calendar converter, top level. Each input beat carries a
// signed Unix time in seconds plus nanoseconds and gives exactly one result
// beat with the local proleptic Gregorian date, time of day and millisecond.
// The user must write the zone offset in minutes west of UTC on the cfg
// channel only while the block is idle; the block does not enforce this.
// Local times outside years 1 to 9999 come back with out_of_range set and
// all other fields zero. A new beat is taken every cycle unless the output
// stalls. Beats pass the front register, the four-entry queue and the
// 14-stage converter pipeline; its day, ms, 400-year, hour, minute and
// 4-year divisions take a multiply, a back-multiply and a correction stage.
`timescale 1ns / 1ps
`include "unix_time_to_calendar_macros.svh"

module unix_time_to_calendar (
  input logic         clk,
  input logic         rst_n,
  utcal_in_if.sink    in_ch,
  utcal_cfg_if.sink   cfg_ch,
  utcal_out_if.source out_ch
);

  utcal_job_if job_q ();
  utcal_job_if job_b ();

  utcal_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .src   (in_ch),
    .cfg   (cfg_ch),
    .job   (job_q)
  );

  utcal_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (job_q),
    .rd    (job_b)
  );

  utcal_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job_b),
    .res   (out_ch)
  );

  `UTCAL_ASSERT_NOW(a_oor_zero, out_ch.valid && out_ch.out_of_range, (out_ch.year == 14'd0) && (out_ch.month == 4'd0) && (out_ch.day_of_month == 5'd0) && (out_ch.hour == 5'd0) && (out_ch.minute == 6'd0) && (out_ch.second == 6'd0) && (out_ch.millisecond == 10'd0), "out of range beat with nonzero fields")
  `UTCAL_ASSERT_NOW(a_fields_legal, out_ch.valid && !out_ch.out_of_range, (out_ch.year >= 14'd1) && (out_ch.year <= 14'd9999) && (out_ch.month >= 4'd1) && (out_ch.month <= 4'd12) && (out_ch.day_of_month >= 5'd1) && (out_ch.hour <= 5'd23) && (out_ch.minute <= 6'd59) && (out_ch.second <= 6'd59) && (out_ch.millisecond <= 10'd999), "result field out of its range")
  `UTCAL_ASSERT_NOW(a_back_stall, out_ch.valid && !out_ch.ready, !job_b.ready, "pipeline advanced while the output beat was held")
  `UTCAL_ASSERT_NEXT(a_front_load, in_ch.valid && in_ch.ready, job_q.valid, "accepted beat missing from the front register")

endmodule
